// File: rtl/core/u2cp_pkg.sv
// ----------------------------------------------------------------------------
// u2cp_pkg: shared types and constants of the code page encoder
// Transfer payloads, the search token that runs down the cell chain, and
// the op codes and character constants.
// ----------------------------------------------------------------------------
package u2cp_pkg;

  // number of table entries, one per cell in the chain
  localparam int TABLE_ENTRIES = 256;

  // op codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_ENC32  = 2'd1;
  localparam logic [1:0] OP_ENC16  = 2'd2;

  // character constants
  localparam logic [15:0] MISS_CHAR  = 16'h005F;
  localparam logic [20:0] PASS_LIMIT = 21'h0000FF;
  localparam logic [20:0] CP_LIMIT   = 21'h110000;
  localparam logic [15:0] LEAD_LO    = 16'hD800;
  localparam logic [15:0] LEAD_HI    = 16'hDBFF;
  // 0x10000 - 0xDC00, added after the lead offset is shifted up
  localparam logic [20:0] SUR_BIAS   = 21'h002400;

  typedef struct packed {
    logic [1:0]  op;
    logic [20:0] code_point;
    logic [15:0] utf16_unit;
    logic [15:0] mapped_code;
  } u2cp_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } u2cp_out_t;

  // token handed from cell to cell
  typedef struct packed {
    logic        active;
    logic        insert;
    logic        emit;
    logic        force_miss;
    logic        hit;
    logic [20:0] key;
    logic [15:0] code;
  } u2cp_tok_t;

endpackage

// File: rtl/core/u2cp_cell.sv
// ----------------------------------------------------------------------------
// u2cp_cell: one table entry of the search chain
// Holds one key/code pair, compares the passing token against it, and
// claims the token's key and code for an insert when the entry is empty.
// ----------------------------------------------------------------------------
module u2cp_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  u2cp_pkg::u2cp_tok_t tok_i,
  output u2cp_pkg::u2cp_tok_t tok_o
);
  import u2cp_pkg::*;

  logic        valid_r;
  logic [20:0] key_r;
  logic [15:0] code_r;
  u2cp_tok_t   tok_r;
  u2cp_tok_t   tok_nxt;
  logic        match;
  logic        take;

  // compare and claim
  assign match = valid_r && (key_r == tok_i.key);
  assign take  = tok_i.active && tok_i.insert && !tok_i.hit && !valid_r;

  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.active && !tok_i.hit && match) begin
      tok_nxt.hit  = 1'b1;
      tok_nxt.code = code_r;
    end
    if (take) begin
      tok_nxt.hit = 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv && take) begin
      valid_r <= 1'b1;
      key_r   <= tok_i.key;
      code_r  <= tok_i.code;
    end
  end

  // token stage toward the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.active <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// File: rtl/core/u2cp_emitter.sv
// ----------------------------------------------------------------------------
// u2cp_emitter: byte output stage
// Takes one 16-bit target code and sends its low byte, then its high byte
// when the code exceeds 0xFF, through a registered output.
// ----------------------------------------------------------------------------
module u2cp_emitter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                code_vld,
  input  logic [15:0]         code,
  output logic                code_rdy,
  output logic                out_valid,
  input  logic                out_stall,
  output u2cp_pkg::u2cp_out_t out_data
);
  import u2cp_pkg::*;

  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       hi_pend_r;
  logic [7:0] hi_r;
  logic       two_byte;

  // a new code fits once the register is empty or its last byte leaves
  assign code_rdy = !out_valid_r || (!out_stall && !hi_pend_r);
  assign two_byte = code > {8'd0, PASS_LIMIT[7:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hi_pend_r   <= 1'b0;
    end else if (code_vld && code_rdy) begin
      // load next code, any finished byte leaves in the same cycle
      out_valid_r <= 1'b1;
      byte_r      <= code[7:0];
      last_r      <= !two_byte;
      hi_pend_r   <= two_byte;
      hi_r        <= code[15:8];
    end else if (out_valid_r && !out_stall) begin
      // drain current byte
      if (hi_pend_r) begin
        byte_r    <= hi_r;
        last_r    <= 1'b1;
        hi_pend_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data.out_byte  = byte_r;
  assign out_data.last_byte = last_r;

endmodule

// File: rtl/core/unicode_to_codepage_encoder.sv
// ----------------------------------------------------------------------------
// unicode_to_codepage_encoder: Unicode to custom code page encoder
// Maps code points through a loaded table to 16-bit codes and sends
// them as one or two bytes.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel in_valid/in_stall/in_data carries one op per transfer:
//   insert a mapping, encode a UTF-32 point, or encode one UTF-16 unit.
//   A lead surrogate is held and joined with the next UTF-16 unit.
// - Output channel out_valid/out_stall/out_data gives encoded bytes, low
//   byte first, last_byte set on the final byte of a character.
// - The table is a chain of TABLE_ENTRIES cells. Every op runs down the
//   chain one cell per cycle while the chain is not frozen, passing through
//   each cell's token register in turn. Ops follow each other through the
//   chain, so one input is taken per cycle unless in_stall is high; a
//   two-byte character holds the output until both its bytes have left.
// - When a finished character waits at the end of the chain and the output
//   stage cannot take it (the receiver stalls, or a high byte is still to
//   be sent), the whole chain freezes and in_stall rises.
// - Reset empties the table and drops any held lead surrogate; the block
//   accepts input in the first cycle after reset.
module unicode_to_codepage_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  u2cp_pkg::u2cp_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output u2cp_pkg::u2cp_out_t out_data
);
  import u2cp_pkg::*;

  logic        pending_r;
  logic        pending_nxt;
  logic [9:0]  lead_r;
  logic [9:0]  lead_nxt;
  logic        accept;
  logic        adv;
  logic        is_lead;
  logic [20:0] comb_pt;
  u2cp_tok_t   head_tok;
  u2cp_tok_t   chain [TABLE_ENTRIES+1];
  u2cp_tok_t   tail_tok;
  logic        tail_need;
  logic [15:0] tail_code;
  logic        code_rdy;

  assign accept   = in_valid && adv;
  assign in_stall = !adv;

  // surrogate decode and token build
  assign is_lead = in_data.utf16_unit inside {[LEAD_LO:LEAD_HI]};
  assign comb_pt = {1'b0, lead_r, 10'd0} + {5'd0, in_data.utf16_unit} + SUR_BIAS;

  always_comb begin
    head_tok      = '0;
    head_tok.key  = in_data.code_point;
    head_tok.code = in_data.mapped_code;
    pending_nxt   = pending_r;
    lead_nxt      = lead_r;
    case (in_data.op)
      OP_INSERT: begin
        head_tok.active = 1'b1;
        head_tok.insert = 1'b1;
      end
      OP_ENC32: begin
        head_tok.active = 1'b1;
        head_tok.emit   = 1'b1;
      end
      OP_ENC16: begin
        if (pending_r) begin
          head_tok.active     = 1'b1;
          head_tok.emit       = 1'b1;
          head_tok.key        = comb_pt;
          head_tok.force_miss = comb_pt >= CP_LIMIT;
          pending_nxt         = 1'b0;
        end else if (is_lead) begin
          pending_nxt = 1'b1;
          lead_nxt    = in_data.utf16_unit[9:0];
        end else begin
          head_tok.active = 1'b1;
          head_tok.emit   = 1'b1;
          head_tok.key    = {5'd0, in_data.utf16_unit};
        end
      end
      default: begin
        head_tok.active = 1'b0;
      end
    endcase
    if (!accept) begin
      head_tok.active = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
    end else if (accept) begin
      pending_r <= pending_nxt;
      lead_r    <= lead_nxt;
    end
  end

  // table cell chain
  assign chain[0] = head_tok;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    u2cp_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (chain[i]),
      .tok_o (chain[i+1])
    );
  end

  // tail translation: hit, pass-through or miss character
  assign tail_tok  = chain[TABLE_ENTRIES];
  assign tail_need = tail_tok.active && tail_tok.emit;

  always_comb begin
    if (tail_tok.hit && !tail_tok.force_miss) begin
      tail_code = tail_tok.code;
    end else if (tail_tok.key < PASS_LIMIT) begin
      tail_code = {8'd0, tail_tok.key[7:0]};
    end else begin
      tail_code = MISS_CHAR;
    end
  end

  // chain moves unless a finished character cannot enter the output stage
  assign adv = !tail_need || code_rdy;

  u2cp_emitter u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .code_vld  (tail_need),
    .code      (tail_code),
    .code_rdy  (code_rdy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/u2cp_checker.sv
// ----------------------------------------------------------------------------
// u2cp_checker: port-level checks of the code page encoder
// Watches the output channel and the input stall over time and is bound to the top level.
// ----------------------------------------------------------------------------
module u2cp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input u2cp_pkg::u2cp_out_t out_data
);
  import u2cp_pkg::*;

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transfer changed");

  // a low byte transfer is followed at once by the high byte
  a_hi_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_byte |=> out_valid && out_data.last_byte)
    else $error("high byte did not follow low byte");

  // output empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // input is never stalled while the output register is free
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind unicode_to_codepage_encoder u2cp_checker u_chk (.*);
